### design/bitmap_text_overlay_pixel_core_assert.svh
// Assertion macros shared by the text overlay modules.
`ifndef BITMAP_TEXT_OVERLAY_PIXEL_CORE_ASSERT_SVH
`define BITMAP_TEXT_OVERLAY_PIXEL_CORE_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define BTOP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never hold outside reset.
`define BTOP_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

### design/btop_pkg.sv
// Types, constants and font tables of the text overlay core.
`timescale 1ns / 1ps

package btop_pkg;

	// Request type codes
	localparam logic [1:0] REQ_WRITE  = 2'd0;
	localparam logic [1:0] REQ_LENGTH = 2'd1;
	localparam logic [1:0] REQ_PIXEL  = 2'd2;

	// Reach of the line and column fields
	localparam int MAX_LINES   = 8;
	localparam int MAX_COLUMNS = 32;

	// Panel geometry
	localparam int BORDER     = 2;
	localparam int MARGIN     = 12;
	localparam int DOT        = 3;
	localparam int CELL_W     = 18;
	localparam int CELL_H     = 27;
	localparam int GLYPH_ROWS = 7;
	localparam int GLYPH_COLS = 5;
	localparam int FONT_COUNT = 37;

	// Reciprocals scaled by 2^16, exact for the pixel ranges in use
	localparam int RECIP_CELL_W = 3641;
	localparam int RECIP_CELL_H = 2428;

	// Power of two, so the pointers wrap on their own
	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_WRITE,
		OP_LENGTH,
		OP_PIXEL
	} op_kind_t;

	typedef struct packed {
		op_kind_t    kind;
		logic [2:0]  line;
		logic [4:0]  column;
		logic [5:0]  value;
		logic [2:0]  dot_row;
		logic [2:0]  dot_col;
		logic        border;
		logic        cand;
	} op_t;

	localparam logic [7:0] FONT_CODE [FONT_COUNT] = '{
		8'h00, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
		8'h41, 8'h43, 8'h44, 8'h45, 8'h47, 8'h49, 8'h4B, 8'h4C, 8'h57, 8'h4D, 8'h4E,
		8'h4F, 8'h50, 8'h52, 8'h53, 8'h54, 8'h56, 8'h58, 8'h59, 8'h5A,
		8'h2E, 8'h2D, 8'h2B, 8'h3A, 8'h28, 8'h29
	};

	localparam logic [7:0] FONT_ROWS [FONT_COUNT][GLYPH_ROWS] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h70, 8'h88, 8'h98, 8'hA8, 8'hC8, 8'h88, 8'h70},
		'{8'h20, 8'h60, 8'h20, 8'h20, 8'h20, 8'h20, 8'h70},
		'{8'h70, 8'h88, 8'h08, 8'h30, 8'h40, 8'h80, 8'hF8},
		'{8'hF0, 8'h08, 8'h10, 8'h30, 8'h08, 8'h88, 8'h70},
		'{8'h10, 8'h30, 8'h50, 8'h90, 8'hF8, 8'h10, 8'h10},
		'{8'hF8, 8'h80, 8'hF0, 8'h08, 8'h08, 8'h88, 8'h70},
		'{8'h70, 8'h80, 8'h80, 8'hF0, 8'h88, 8'h88, 8'h70},
		'{8'hF8, 8'h08, 8'h10, 8'h20, 8'h40, 8'h40, 8'h40},
		'{8'h70, 8'h88, 8'h88, 8'h70, 8'h88, 8'h88, 8'h70},
		'{8'h70, 8'h88, 8'h88, 8'h78, 8'h08, 8'h08, 8'h70},
		'{8'h70, 8'h88, 8'h88, 8'hF8, 8'h88, 8'h88, 8'h88},
		'{8'h70, 8'h88, 8'h80, 8'h80, 8'h80, 8'h88, 8'h70},
		'{8'hE0, 8'h90, 8'h88, 8'h88, 8'h88, 8'h90, 8'hE0},
		'{8'hF8, 8'h80, 8'h80, 8'hF0, 8'h80, 8'h80, 8'hF8},
		'{8'h70, 8'h88, 8'h80, 8'hB8, 8'h88, 8'h88, 8'h70},
		'{8'h70, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h70},
		'{8'h88, 8'h90, 8'hA0, 8'hC0, 8'hA0, 8'h90, 8'h88},
		'{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'hF8},
		'{8'h88, 8'h88, 8'h88, 8'hA8, 8'hA8, 8'hD8, 8'h88},
		'{8'h88, 8'hD8, 8'hA8, 8'hA8, 8'h88, 8'h88, 8'h88},
		'{8'h88, 8'hC8, 8'hA8, 8'h98, 8'h88, 8'h88, 8'h88},
		'{8'h70, 8'h88, 8'h88, 8'h88, 8'h88, 8'h88, 8'h70},
		'{8'hF0, 8'h88, 8'h88, 8'hF0, 8'h80, 8'h80, 8'h80},
		'{8'hF0, 8'h88, 8'h88, 8'hF0, 8'hA0, 8'h90, 8'h88},
		'{8'h70, 8'h88, 8'h80, 8'h70, 8'h08, 8'h88, 8'h70},
		'{8'hF8, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20, 8'h20},
		'{8'h88, 8'h88, 8'h88, 8'h88, 8'h88, 8'h50, 8'h20},
		'{8'h88, 8'h88, 8'h50, 8'h20, 8'h50, 8'h88, 8'h88},
		'{8'h88, 8'h88, 8'h50, 8'h20, 8'h20, 8'h20, 8'h20},
		'{8'hF8, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hF8},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h60, 8'h60},
		'{8'h00, 8'h00, 8'h00, 8'hF0, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h20, 8'h20, 8'hF8, 8'h20, 8'h20, 8'h00},
		'{8'h00, 8'h60, 8'h60, 8'h00, 8'h60, 8'h60, 8'h00},
		'{8'h20, 8'h40, 8'h80, 8'h80, 8'h80, 8'h40, 8'h20},
		'{8'h20, 8'h10, 8'h08, 8'h08, 8'h08, 8'h10, 8'h20}
	};

	// Fold lowercase, then find the glyph; no match gives blank
	function automatic logic [5:0] code_to_index(input logic [7:0] code);
		logic [7:0] folded;
		logic [5:0] idx;
		folded = code;
		idx    = '0;
		if (code >= 8'h61 && code <= 8'h7A) begin
			folded = code - 8'h20;
		end
		for (int i = 1; i < FONT_COUNT; i++) begin
			if (FONT_CODE[i] == folded) begin
				idx = 6'(i);
			end
		end
		return idx;
	endfunction

	// Dot index within a cell offset below 32
	function automatic logic [2:0] div_by_dot(input logic [4:0] v);
		logic [2:0] q;
		q = '0;
		for (int i = 1; i <= 7; i++) begin
			if (int'(v) >= DOT * i) begin
				q = q + 3'd1;
			end
		end
		return q;
	endfunction

	function automatic logic font_bit(input logic [5:0] glyph, input logic [2:0] row,
			input logic [2:0] col);
		logic [7:0] bits;
		bits = '0;
		if (int'(glyph) < FONT_COUNT && int'(row) < GLYPH_ROWS) begin
			bits = FONT_ROWS[glyph][row];
		end
		return bits[3'd7 - col];
	endfunction

endpackage

### design/btop_if.sv
// Request and result channel interfaces of the text overlay core.
`timescale 1ns / 1ps

interface btop_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [2:0] text_line;
	logic [4:0] text_column;
	logic [7:0] char_code;
	logic [5:0] line_length;
	logic [8:0] pixel_x;
	logic [7:0] pixel_y;

	modport source (
		output valid, req_type, text_line, text_column, char_code, line_length,
			pixel_x, pixel_y,
		input  ready
	);
	modport sink (
		input  valid, req_type, text_line, text_column, char_code, line_length,
			pixel_x, pixel_y,
		output ready
	);
endinterface

interface btop_res_if;
	logic valid;
	logic ready;
	logic pixel_lit;

	modport source (output valid, pixel_lit, input ready);
	modport sink (input valid, pixel_lit, output ready);
endinterface

### design/btop_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module btop_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### design/btop_queue.sv
// Short operation queue between the classifying front and the executing back.
`timescale 1ns / 1ps
`include "bitmap_text_overlay_pixel_core_assert.svh"

module btop_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  btop_pkg::op_t push_op,
	output logic          full,
	output logic          q_valid,
	output btop_pkg::op_t q_op,
	input  logic          pop
);
	import btop_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	op_t            entry_q [QUEUE_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full    = (count_q == CW'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign q_op    = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	`BTOP_NEVER(a_queue_overflow, push && !pop && full, "queue pushed while full")
	`BTOP_NEVER(a_queue_underflow, pop && !q_valid, "queue popped while empty")

endmodule

### design/btop_front.sv
// Front end: accepts requests, maps pixels onto text cells, classifies operations.
`timescale 1ns / 1ps
`include "bitmap_text_overlay_pixel_core_assert.svh"

module btop_front #(
	parameter int PANEL_WIDTH  = 512,
	parameter int PANEL_HEIGHT = 256,
	parameter int TEXT_COLUMNS = 32,
	parameter int EFF_LINES    = 8,
	parameter int EFF_COLS     = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	btop_req_if.sink      req,
	output logic          push,
	output btop_pkg::op_t push_op,
	input  logic          full
);
	import btop_pkg::*;

	// Lines whose glyph fits above the bottom margin; columns left of the right one
	localparam int LINE_DRAWN = (PANEL_HEIGHT - 2 * MARGIN - GLYPH_ROWS * DOT) / CELL_H + 1;
	localparam int COL_DRAWN  = (PANEL_WIDTH - 2 * MARGIN - CELL_W) / CELL_W + 1;

	op_kind_t    kind_a;
	logic [5:0]  value_a;
	logic        border_a;
	logic        inner_a;
	logic [8:0]  dx_a;
	logic [7:0]  dy_a;
	logic [20:0] k_prod;
	logic [19:0] li_prod;

	logic        s1_valid;
	op_kind_t    s1_kind;
	logic [2:0]  s1_line;
	logic [4:0]  s1_column;
	logic [5:0]  s1_value;
	logic        s1_border;
	logic        s1_inner;
	logic [8:0]  s1_dx;
	logic [7:0]  s1_dy;
	logic [3:0]  s1_li;
	logic [4:0]  s1_k;

	logic [8:0]  ry_full;
	logic [9:0]  rx_full;
	logic [4:0]  ry;
	logic [4:0]  rx;
	logic        cand;

	always_comb begin
		kind_a  = OP_NONE;
		value_a = '0;
		unique case (req.req_type)
			REQ_WRITE: begin
				if (int'(req.text_line) < EFF_LINES && int'(req.text_column) < EFF_COLS) begin
					kind_a = OP_WRITE;
				end
				value_a = code_to_index(req.char_code);
			end
			REQ_LENGTH: begin
				if (int'(req.text_line) < EFF_LINES) begin
					kind_a = OP_LENGTH;
				end
				value_a = (int'(req.line_length) > TEXT_COLUMNS) ? 6'(TEXT_COLUMNS)
					: req.line_length;
			end
			REQ_PIXEL: kind_a = OP_PIXEL;
			default:   kind_a = OP_NONE;
		endcase
	end

	assign border_a = int'(req.pixel_x) < BORDER || int'(req.pixel_x) >= PANEL_WIDTH - BORDER ||
		int'(req.pixel_y) < BORDER || int'(req.pixel_y) >= PANEL_HEIGHT - BORDER;
	assign inner_a  = req.pixel_x >= 9'(MARGIN) && req.pixel_y >= 8'(MARGIN);
	assign dx_a     = req.pixel_x - 9'(MARGIN);
	assign dy_a     = req.pixel_y - 8'(MARGIN);
	assign k_prod   = 21'(dx_a) * 21'(RECIP_CELL_W);
	assign li_prod  = 20'(dy_a) * 20'(RECIP_CELL_H);

	assign req.ready = !s1_valid || !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s1_kind  <= OP_NONE;
		end else if (req.ready) begin
			// drop requests that change nothing and give no result
			s1_valid <= req.valid && kind_a != OP_NONE;
			s1_kind  <= kind_a;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			s1_line   <= req.text_line;
			s1_column <= req.text_column;
			s1_value  <= value_a;
			s1_border <= border_a;
			s1_inner  <= inner_a;
			s1_dx     <= dx_a;
			s1_dy     <= dy_a;
			s1_li     <= li_prod[19:16];
			s1_k      <= k_prod[20:16];
		end
	end

	// Offsets inside the character cell
	assign ry_full = 9'(s1_dy) - 9'(s1_li) * 9'(CELL_H);
	assign rx_full = 10'(s1_dx) - 10'(s1_k) * 10'(CELL_W);
	assign ry      = ry_full[4:0];
	assign rx      = rx_full[4:0];

	assign cand = s1_inner && int'(ry) < GLYPH_ROWS * DOT && int'(rx) < GLYPH_COLS * DOT &&
		int'(s1_li) < EFF_LINES && int'(s1_li) < LINE_DRAWN &&
		int'(s1_k) < COL_DRAWN && int'(s1_k) < EFF_COLS;

	always_comb begin
		push_op.kind    = s1_kind;
		push_op.line    = s1_line;
		push_op.column  = s1_column;
		push_op.value   = s1_value;
		push_op.dot_row = div_by_dot(ry);
		push_op.dot_col = div_by_dot(rx);
		push_op.border  = s1_border;
		push_op.cand    = cand;
		if (s1_kind == OP_PIXEL) begin
			push_op.line   = s1_li[2:0];
			push_op.column = s1_k;
		end
	end

	assign push = s1_valid && !full;

	`BTOP_ASSERT(a_pixel_enters_stage, req.valid && req.ready && req.req_type == REQ_PIXEL |=> s1_valid && s1_kind == OP_PIXEL, "pixel request lost in front stage")

endmodule

### design/btop_back.sv
// Back end: updates the text store and line lengths, looks up glyph dots.
`timescale 1ns / 1ps
`include "bitmap_text_overlay_pixel_core_assert.svh"

module btop_back #(
	parameter int EFF_LINES = 8,
	parameter int EFF_COLS  = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  btop_pkg::op_t q_op,
	output logic          pop,
	btop_res_if.source    res
);
	import btop_pkg::*;

	localparam int DEPTH = EFF_LINES * EFF_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW    = (EFF_LINES > 1) ? $clog2(EFF_LINES) : 1;

	logic             adv;
	logic             do_write;
	logic             do_length;
	logic             do_pixel;
	logic [AW-1:0]    addr;
	logic [LW-1:0]    line_idx;
	logic             len_hit;
	logic [5:0]       ram_rdata;
	logic [5:0]       glyph;
	logic             lit;

	logic [DEPTH-1:0] cell_valid_q;
	logic [5:0]       len_q [EFF_LINES];

	logic             s1_valid;
	logic             s1_border;
	logic             s1_hit;
	logic             s1_cell_valid;
	logic [2:0]       s1_row;
	logic [2:0]       s1_col;

	logic             res_valid_q;
	logic             res_lit_q;

	// Hold the whole back end while a result waits
	assign adv       = !res_valid_q || res.ready;
	assign pop       = adv && q_valid;
	assign do_write  = pop && q_op.kind == OP_WRITE;
	assign do_length = pop && q_op.kind == OP_LENGTH;
	assign do_pixel  = pop && q_op.kind == OP_PIXEL;

	assign addr     = AW'(int'(q_op.line) * EFF_COLS + int'(q_op.column));
	assign line_idx = q_op.line[LW-1:0];
	assign len_hit  = q_op.cand && 6'(q_op.column) < len_q[line_idx];

	btop_ram #(
		.WIDTH (6),
		.DEPTH (DEPTH)
	) u_glyph_ram (
		.clk   (clk),
		.we    (do_write),
		.waddr (addr),
		.wdata (q_op.value),
		.re    (do_pixel),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_valid_q <= '0;
			for (int i = 0; i < EFF_LINES; i++) begin
				len_q[i] <= '0;
			end
		end else begin
			if (do_write) begin
				cell_valid_q[addr] <= 1'b1;
			end
			if (do_length) begin
				len_q[line_idx] <= q_op.value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid    <= do_pixel;
			res_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pixel) begin
			s1_border     <= q_op.border;
			s1_hit        <= len_hit;
			s1_cell_valid <= q_op.cand && cell_valid_q[addr];
			s1_row        <= q_op.dot_row;
			s1_col        <= q_op.dot_col;
		end
		if (adv) begin
			res_lit_q <= lit;
		end
	end

	// Never-written cells read as blank
	assign glyph = s1_cell_valid ? ram_rdata : '0;
	assign lit   = s1_border || (s1_hit && font_bit(glyph, s1_row, s1_col));

	assign res.valid     = res_valid_q;
	assign res.pixel_lit = res_lit_q;

	`BTOP_ASSERT(a_write_marks_cell, do_write |=> cell_valid_q[$past(addr)], "written cell not marked valid")
	`BTOP_ASSERT(a_result_from_read, res.valid && !$past(res.valid) |-> $past(s1_valid), "result without a pixel read")
	`BTOP_ASSERT(a_border_lit, $past(adv && s1_valid && s1_border) |-> res.pixel_lit, "border pixel not lit")

endmodule

### design/bitmap_text_overlay_pixel_core.sv
// Top level of the bitmap text overlay pixel core.
`timescale 1ns / 1ps

// Text overlay character generator.
// The req channel carries three request types: write a character into a line and
// column cell (lowercase folds to uppercase, codes without a glyph store blank),
// set how many characters of a line are drawn, and read one panel pixel. Only a
// pixel read returns an item on the res channel: pixel_lit, 1 white, 0 black.
// Pixels within 2 of a panel edge are lit; inside a 12 pixel margin the panel is
// cut into 18x27 cells that show a 5x7 glyph of 3x3 dots.
// A request passes a front register, a four entry queue and a back stage that reads
// the text store RAM and registers the pixel result. One request enters per clock
// while req.ready is high, so a display scan streams one pixel per cycle; a single
// glyph store read port sets that figure.
// Requests complete in order: a read after a write to the same cell sees the write.
// Reset clears the text store to blank through per-cell valid bits and zeroes all
// line lengths at once; requests are taken from the first cycle after reset.
// When res is stalled the result holds and the back end waits; the queue and the
// front register go on taking requests until they fill, then req.ready drops.
module bitmap_text_overlay_pixel_core #(
	parameter int PANEL_WIDTH  = 512,
	parameter int PANEL_HEIGHT = 256,
	parameter int TEXT_LINES   = 8,
	parameter int TEXT_COLUMNS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	btop_req_if.sink   req,
	btop_res_if.source res
);
	import btop_pkg::*;

	// Cells reachable through the line and column fields
	localparam int EFF_LINES = (TEXT_LINES < MAX_LINES) ? TEXT_LINES : MAX_LINES;
	localparam int EFF_COLS  = (TEXT_COLUMNS < MAX_COLUMNS) ? TEXT_COLUMNS : MAX_COLUMNS;

	logic push;
	op_t  push_op;
	logic full;
	logic q_valid;
	op_t  q_op;
	logic pop;

	btop_front #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT),
		.TEXT_COLUMNS (TEXT_COLUMNS),
		.EFF_LINES    (EFF_LINES),
		.EFF_COLS     (EFF_COLS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.push    (push),
		.push_op (push_op),
		.full    (full)
	);

	btop_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (full),
		.q_valid (q_valid),
		.q_op    (q_op),
		.pop     (pop)
	);

	btop_back #(
		.EFF_LINES (EFF_LINES),
		.EFF_COLS  (EFF_COLS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_op    (q_op),
		.pop     (pop),
		.res     (res)
	);

endmodule
